/* hw/rtl/ffsa_pkg.sv */
// Shared types and constants for the first-fit slot allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ffsa_pkg;

   localparam int SLOTS_DEF = 64;

   localparam int NAME_W   = 40;
   localparam int KIND_W   = 3;
   localparam int SIZE_W   = 7;
   localparam int STATUS_W = 3;
   localparam int BASE_W   = 6;
   localparam int COUNT_W  = 7;
   localparam int FREE_W   = 7;

   // five ASCII spaces form the blank name, which an allocate refuses
   localparam logic [NAME_W-1:0] BLANK_TAG = 40'h20_2020_2020;

   localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SWOUT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SWIN  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EVICT = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOSPACE  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_BADSIZE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SCAN_COUNT,
      SCAN_FIT,
      SCAN_CLEAR
   } scan_mode_type;

   typedef enum logic {
      STORE_PRI,
      STORE_BAK
   } store_type;

   // controller to datapath
   typedef struct packed {
      logic          load;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          fill_start;
      store_type     sel;
      logic          len_from_cnt;
      logic          target_from_last;
      logic          rsp_load;
      status_type    rsp_status;
      logic          from_clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              name_blank;
      logic              size_zero;
      logic              busy;
      logic              cnt_zero;
      logic              fit_found;
      logic              any_valid;
      logic              out_busy;
   } stat_type;

endpackage

/* hw/rtl/ffsa_req_if.sv */
// Request channel of the slot allocator: valid/ready plus the request fields.
// Depends on ffsa_pkg for field widths.
interface ffsa_req_if;
   import ffsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [NAME_W-1:0]   proc_name;
   logic [SIZE_W-1:0]   req_size;

   modport source (output valid, output kind, output proc_name, output req_size,
                   input ready);
   modport sink   (input valid, input kind, input proc_name, input req_size,
                   output ready);
endinterface

/* hw/rtl/ffsa_rsp_if.sv */
// Response channel of the slot allocator: valid/ready plus the result fields.
// Depends on ffsa_pkg for field widths.
interface ffsa_rsp_if;
   import ffsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BASE_W-1:0]   base_slot;
   logic [COUNT_W-1:0]  slot_count;
   logic [FREE_W-1:0]   free_slots;

   modport source (output valid, output status, output base_slot, output slot_count,
                   output free_slots, input ready);
   modport sink   (input valid, input status, input base_slot, input slot_count,
                   input free_slots, output ready);
endinterface

/* hw/rtl/ffsa_ctrl.sv */
// Operation sequencer of the slot allocator: walks each request through its scan,
// fill and clear passes. Depends on ffsa_pkg; drives ffsa_dp through cmd_type.
module ffsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output ffsa_pkg::cmd_type  cmd,
   input  ffsa_pkg::stat_type stat
);
   import ffsa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_ALLOC_SCAN,
      S_FREE_SCAN,
      S_SW_COUNT,
      S_SW_FIT,
      S_SW_FILL,
      S_EV_SCAN,
      S_FINISH,
      S_RESP
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       from_clear_ff, from_clear_in;
   store_type  src_store, dst_store;

   // swap direction follows the latched kind
   assign src_store = (stat.kind == KIND_SWOUT) ? STORE_PRI : STORE_BAK;
   assign dst_store = (stat.kind == KIND_SWOUT) ? STORE_BAK : STORE_PRI;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      from_clear_in = from_clear_ff;
      cmd           = '0;
      cmd.rsp_status = status_ff;
      cmd.from_clear = from_clear_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in     = ST_OK;
            from_clear_in = 1'b0;
            unique case (stat.kind)
               KIND_ALLOC: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = SCAN_COUNT;
                  cmd.sel        = STORE_PRI;
                  state_in       = S_ALLOC_SCAN;
               end
               KIND_FREE: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = SCAN_CLEAR;
                  cmd.sel        = STORE_PRI;
                  state_in       = S_FREE_SCAN;
               end
               KIND_SWOUT, KIND_SWIN: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = SCAN_COUNT;
                  cmd.sel        = src_store;
                  state_in       = S_SW_COUNT;
               end
               KIND_EVICT: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = SCAN_COUNT;
                  cmd.sel        = STORE_PRI;
                  state_in       = S_EV_SCAN;
               end
               default: begin
                  status_in = ST_BADSIZE;
                  state_in  = S_RESP;
               end
            endcase
         end
         S_ALLOC_SCAN: begin
            if (!stat.busy) begin
               if (stat.name_blank || !stat.cnt_zero) begin
                  status_in = ST_DUP;
                  state_in  = S_RESP;
               end else if (stat.size_zero) begin
                  status_in = ST_BADSIZE;
                  state_in  = S_RESP;
               end else if (!stat.fit_found) begin
                  status_in = ST_NOSPACE;
                  state_in  = S_RESP;
               end else begin
                  cmd.fill_start = 1'b1;
                  cmd.sel        = STORE_PRI;
                  state_in       = S_FINISH;
               end
            end
         end
         S_FREE_SCAN: begin
            if (!stat.busy) begin
               if (stat.cnt_zero) begin
                  status_in = ST_NOTFOUND;
               end else begin
                  from_clear_in = 1'b1;
               end
               state_in = S_RESP;
            end
         end
         S_SW_COUNT: begin
            if (!stat.busy) begin
               if (stat.cnt_zero) begin
                  status_in = ST_NOTFOUND;
                  state_in  = S_RESP;
               end else begin
                  cmd.len_from_cnt = 1'b1;
                  cmd.scan_start   = 1'b1;
                  cmd.scan_mode    = SCAN_FIT;
                  cmd.sel          = dst_store;
                  state_in         = S_SW_FIT;
               end
            end
         end
         S_SW_FIT: begin
            if (!stat.busy) begin
               if (!stat.fit_found) begin
                  status_in = ST_NOSPACE;
                  state_in  = S_RESP;
               end else begin
                  cmd.fill_start = 1'b1;
                  cmd.sel        = dst_store;
                  state_in       = S_SW_FILL;
               end
            end
         end
         S_SW_FILL: begin
            if (!stat.busy) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SCAN_CLEAR;
               cmd.sel        = src_store;
               state_in       = S_FINISH;
            end
         end
         S_EV_SCAN: begin
            if (!stat.busy) begin
               if (!stat.any_valid) begin
                  status_in = ST_NOTFOUND;
                  state_in  = S_RESP;
               end else begin
                  // clear every slot owned by the tag found highest up
                  cmd.target_from_last = 1'b1;
                  cmd.scan_start       = 1'b1;
                  cmd.scan_mode        = SCAN_CLEAR;
                  cmd.sel              = STORE_PRI;
                  from_clear_in        = 1'b1;
                  state_in             = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!stat.busy) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!stat.out_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         status_ff     <= ST_OK;
         from_clear_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         status_ff     <= status_in;
         from_clear_ff <= from_clear_in;
      end
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted request did not move to dispatch");

   a_start_when_quiet: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_start || cmd.fill_start) |-> !stat.busy)
      else $error("pass started while another pass is running");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !stat.out_busy)
      else $error("response loaded over one not yet taken");

endmodule

/* hw/rtl/ffsa_dp.sv */
// Datapath of the slot allocator: both tag stores, their occupancy bits, the
// scan pipeline, the fill sequencer and the response register. Depends on ffsa_pkg.
module ffsa_dp #(
   parameter int SLOTS = ffsa_pkg::SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ffsa_pkg::cmd_type                cmd,
   output ffsa_pkg::stat_type               stat,
   input  logic [ffsa_pkg::KIND_W-1:0]      req_kind,
   input  logic [ffsa_pkg::NAME_W-1:0]      req_proc_name,
   input  logic [ffsa_pkg::SIZE_W-1:0]      req_size,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ffsa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ffsa_pkg::BASE_W-1:0]      rsp_base_slot,
   output logic [ffsa_pkg::COUNT_W-1:0]     rsp_slot_count,
   output logic [ffsa_pkg::FREE_W-1:0]      rsp_free_slots
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;

   // tag stores; a slot whose occupancy bit is low reads as free
   logic [NAME_W-1:0] p_mem [SLOTS];
   logic [NAME_W-1:0] b_mem [SLOTS];
   logic [NAME_W-1:0] p_rd_ff, b_rd_ff;

   logic [SLOTS-1:0]  p_vld_ff, p_vld_in;
   logic [SLOTS-1:0]  b_vld_ff, b_vld_in;
   logic [CW-1:0]     free_cnt_ff, free_cnt_in;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [NAME_W-1:0] target_ff, target_in;
   logic [LW-1:0]     len_ff, len_in;

   logic              scan_on_ff, scan_on_in;
   logic [IW-1:0]     scan_idx_ff, scan_idx_in;
   logic              s1_on_ff, s1_on_in;
   logic [IW-1:0]     s1_idx_ff, s1_idx_in;
   scan_mode_type     mode_ff, mode_in;
   store_type         sel_ff, sel_in;

   logic              fill_on_ff, fill_on_in;
   logic [CW-1:0]     fill_k_ff, fill_k_in;

   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [IW-1:0]     low_ff, low_in;
   logic              any_ff, any_in;
   logic [NAME_W-1:0] last_ff, last_in;
   logic [CW-1:0]     run_ff, run_in;
   logic              fit_ff, fit_in;
   logic [IW-1:0]     fit_base_ff, fit_base_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [BASE_W-1:0] rsp_base_ff, rsp_base_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [FREE_W-1:0] rsp_free_ff, rsp_free_in;

   logic [NAME_W-1:0] s1_tag;
   logic              s1_vld;
   logic              s1_hit;
   logic              fit_step;
   logic [CW-1:0]     run_next;
   logic [LW:0]       fit_calc;
   logic [IW-1:0]     fill_addr;

   assign s1_tag    = (sel_ff == STORE_BAK) ? b_rd_ff : p_rd_ff;
   assign s1_vld    = (sel_ff == STORE_BAK) ? b_vld_ff[s1_idx_ff] : p_vld_ff[s1_idx_ff];
   assign s1_hit    = s1_vld && (s1_tag == target_ff);
   assign fit_step  = s1_on_ff && ((mode_ff == SCAN_COUNT) || (mode_ff == SCAN_FIT));
   assign run_next  = run_ff + CW'(1);
   assign fit_calc  = (LW+1)'(s1_idx_ff) + (LW+1)'(1) - (LW+1)'(len_ff);
   assign fill_addr = fit_base_ff + IW'(fill_k_ff);

   always_comb begin
      p_vld_in      = p_vld_ff;
      b_vld_in      = b_vld_ff;
      free_cnt_in   = free_cnt_ff;
      kind_in       = kind_ff;
      target_in     = target_ff;
      len_in        = len_ff;
      scan_on_in    = scan_on_ff;
      scan_idx_in   = scan_idx_ff;
      s1_on_in      = scan_on_ff;
      s1_idx_in     = scan_idx_ff;
      mode_in       = mode_ff;
      sel_in        = sel_ff;
      fill_on_in    = fill_on_ff;
      fill_k_in     = fill_k_ff;
      cnt_in        = cnt_ff;
      low_in        = low_ff;
      any_in        = any_ff;
      last_in       = last_ff;
      run_in        = run_ff;
      fit_in        = fit_ff;
      fit_base_in   = fit_base_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_free_in   = rsp_free_ff;

      if (cmd.load) begin
         kind_in   = req_kind;
         target_in = req_proc_name;
         len_in    = LW'(req_size);
      end
      if (cmd.len_from_cnt) begin
         len_in = LW'(cnt_ff);
      end
      if (cmd.target_from_last) begin
         target_in = last_ff;
      end

      // issue one read address a cycle
      if (scan_on_ff) begin
         scan_idx_in = scan_idx_ff + IW'(1);
         if (scan_idx_ff == IW'(SLOTS - 1)) begin
            scan_on_in = 1'b0;
         end
      end

      // evaluate the slot whose tag came back
      if (s1_on_ff) begin
         case (mode_ff)
            SCAN_COUNT: begin
               if (s1_hit) begin
                  cnt_in = cnt_ff + CW'(1);
                  if (cnt_ff == '0) begin
                     low_in = s1_idx_ff;
                  end
               end
               if (s1_vld) begin
                  any_in  = 1'b1;
                  last_in = s1_tag;
               end
            end
            SCAN_CLEAR: begin
               if (s1_hit) begin
                  cnt_in = cnt_ff + CW'(1);
                  if (cnt_ff == '0) begin
                     low_in = s1_idx_ff;
                  end
                  if (sel_ff == STORE_BAK) begin
                     b_vld_in[s1_idx_ff] = 1'b0;
                  end else begin
                     p_vld_in[s1_idx_ff] = 1'b0;
                     free_cnt_in         = free_cnt_ff + CW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // first free run of len_ff slots
      if (fit_step) begin
         if (!s1_vld) begin
            run_in = run_next;
            if (!fit_ff && (LW'(run_next) == len_ff)) begin
               fit_in      = 1'b1;
               fit_base_in = IW'(fit_calc);
            end
         end else begin
            run_in = '0;
         end
      end

      if (fill_on_ff) begin
         if (sel_ff == STORE_BAK) begin
            b_vld_in[fill_addr] = 1'b1;
         end else begin
            p_vld_in[fill_addr] = 1'b1;
            free_cnt_in         = free_cnt_ff - CW'(1);
         end
         fill_k_in = fill_k_ff + CW'(1);
         if (LW'(fill_k_ff) == len_ff - LW'(1)) begin
            fill_on_in = 1'b0;
         end
      end

      if (cmd.scan_start) begin
         scan_on_in  = 1'b1;
         scan_idx_in = '0;
         mode_in     = cmd.scan_mode;
         sel_in      = cmd.sel;
         case (cmd.scan_mode)
            SCAN_COUNT: begin
               cnt_in  = '0;
               low_in  = '0;
               any_in  = 1'b0;
               last_in = BLANK_TAG;
               run_in  = '0;
               fit_in  = 1'b0;
            end
            SCAN_FIT: begin
               run_in = '0;
               fit_in = 1'b0;
            end
            SCAN_CLEAR: begin
               cnt_in = '0;
               low_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.fill_start) begin
         fill_on_in = 1'b1;
         fill_k_in  = '0;
         sel_in     = cmd.sel;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         rsp_free_in   = FREE_W'(free_cnt_ff);
         if (cmd.rsp_status == ST_OK) begin
            rsp_base_in  = cmd.from_clear ? BASE_W'(low_ff) : BASE_W'(fit_base_ff);
            rsp_count_in = cmd.from_clear ? COUNT_W'(cnt_ff) : COUNT_W'(len_ff);
         end else begin
            rsp_base_in  = '0;
            rsp_count_in = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // tag memories: one write (fill) and one registered read (scan) per cycle
   always_ff @(posedge clock) begin
      if (fill_on_ff && (sel_ff == STORE_PRI)) begin
         p_mem[fill_addr] <= target_ff;
      end
      if (fill_on_ff && (sel_ff == STORE_BAK)) begin
         b_mem[fill_addr] <= target_ff;
      end
      p_rd_ff <= p_mem[scan_idx_ff];
      b_rd_ff <= b_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff     <= '0;
         b_vld_ff     <= '0;
         free_cnt_ff  <= CW'(SLOTS);
         scan_on_ff   <= 1'b0;
         s1_on_ff     <= 1'b0;
         fill_on_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_vld_ff     <= p_vld_in;
         b_vld_ff     <= b_vld_in;
         free_cnt_ff  <= free_cnt_in;
         scan_on_ff   <= scan_on_in;
         s1_on_ff     <= s1_on_in;
         fill_on_ff   <= fill_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      target_ff     <= target_in;
      len_ff        <= len_in;
      scan_idx_ff   <= scan_idx_in;
      s1_idx_ff     <= s1_idx_in;
      mode_ff       <= mode_in;
      sel_ff        <= sel_in;
      fill_k_ff     <= fill_k_in;
      cnt_ff        <= cnt_in;
      low_ff        <= low_in;
      any_ff        <= any_in;
      last_ff       <= last_in;
      run_ff        <= run_in;
      fit_ff        <= fit_in;
      fit_base_ff   <= fit_base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign stat.kind       = kind_ff;
   assign stat.name_blank = (target_ff == BLANK_TAG);
   assign stat.size_zero  = (len_ff == '0);
   assign stat.busy       = scan_on_ff || s1_on_ff || fill_on_ff;
   assign stat.cnt_zero   = (cnt_ff == '0);
   assign stat.fit_found  = fit_ff;
   assign stat.any_valid  = any_ff;
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_base_slot  = rsp_base_ff;
   assign rsp_slot_count = rsp_count_ff;
   assign rsp_free_slots = rsp_free_ff;

   a_scan_fill_apart: assert property (@(posedge clock) disable iff (reset)
      !(scan_on_ff && fill_on_ff))
      else $error("scan and fill running together");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= CW'(SLOTS))
      else $error("free slot count above store size");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |->
         ((rsp_base_ff == '0) && (rsp_count_ff == '0)))
      else $error("failed request reports a base or a count");

endmodule

/* hw/rtl/first_fit_slot_allocator_with_swap_top.sv */
// First-fit slot allocator with a backing store for swapping: a primary and a
// backing store of SLOTS tag slots each. Every request gives one response.
// Each pass walks a store one slot per cycle through its single read port. Free
// is a clearing scan, allocate a count scan and a fill, evict a count and a
// clearing scan, swap a count, a fit, a fill and a clearing scan; a failing
// check ends the request right after the scan that detects it. The next request
// is taken once the current one has reached the response register, which holds
// it until taken. Stores come out of reset free, with no clearing pass.
module first_fit_slot_allocator_with_swap_top #(
   parameter int SLOTS = ffsa_pkg::SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   ffsa_req_if.sink         req_bus,
   ffsa_rsp_if.source       rsp_bus
);
   import ffsa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ffsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ffsa_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_bus.kind),
      .req_proc_name  (req_bus.proc_name),
      .req_size       (req_bus.req_size),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_status     (rsp_bus.status),
      .rsp_base_slot  (rsp_bus.base_slot),
      .rsp_slot_count (rsp_bus.slot_count),
      .rsp_free_slots (rsp_bus.free_slots)
   );

endmodule
